// File: hw/rtl/lbf_pkg.sv
// Shared types and constants for the line break finder.
// No dependencies; used by every module of the block.
package lbf_pkg;

  localparam int CHAR_BITS    = 8;
  localparam int WIDTH_BITS   = 12;
  localparam int COL_BITS     = 13;
  localparam int OFFSET_BITS  = 16;
  localparam int OUTCOME_BITS = 3;
  localparam int CFG_IDX_BITS = 1;
  // Tab stops must stay a power of two: the column remainder is a mask.
  localparam int TAB_WIDTH    = 8;
  localparam int TAB_BITS     = $clog2(TAB_WIDTH);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [WIDTH_BITS-1:0]  MAX_WIDTH_RESET = WIDTH_BITS'(80);

  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'd0;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_BITS-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'd32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAX_WIDTH       = 1'b0,
    REG_OVERFLOW_REPORT = 1'b1
  } lbf_reg_t;

  typedef enum logic [OUTCOME_BITS-1:0] {
    OUT_END_TEXT     = 3'd0,
    OUT_NEWLINE      = 3'd1,
    OUT_WORD_BREAK   = 3'd2,
    OUT_NO_BREAK     = 3'd3,
    OUT_OVF_REPORT   = 3'd4,
    OUT_OVF_EXTEND   = 3'd5
  } lbf_outcome_t;

  typedef enum logic [2:0] {
    PH_DONE   = 3'b001,
    PH_SCAN   = 3'b010,
    PH_EXTEND = 3'b100
  } lbf_phase_t;

  typedef struct packed {
    lbf_phase_t             phase;
    logic [COL_BITS-1:0]    col;
    logic                   in_word;
    logic [OFFSET_BITS-1:0] last_word_end;
    logic                   word_end_seen;
    logic [OFFSET_BITS-1:0] byte_index;
  } lbf_state_t;

  typedef struct packed {
    logic                   emit;
    logic [OFFSET_BITS-1:0] offset;
    lbf_outcome_t           outcome;
  } lbf_result_t;

endpackage

// File: hw/rtl/lbf_step.sv
// Per-byte scan logic: next scan state and the optional result for one item.
// Depends on lbf_pkg.
module lbf_step (
  input  logic [lbf_pkg::CHAR_BITS-1:0]  char_code,
  input  logic                           start_of_text,
  input  lbf_pkg::lbf_state_t            state,
  input  logic [lbf_pkg::WIDTH_BITS-1:0] max_width,
  input  logic                           overflow_report,
  output lbf_pkg::lbf_state_t            state_next,
  output lbf_pkg::lbf_result_t           result
);

  lbf_pkg::lbf_state_t              cur;
  logic                             is_blank;
  logic                             is_ctrl_or_high;
  logic [lbf_pkg::OFFSET_BITS-1:0]  index_inc;
  logic [lbf_pkg::TAB_BITS:0]       tab_step;
  logic [lbf_pkg::COL_BITS-1:0]     col_add;

  always_comb begin
    cur = state;
    if (start_of_text) begin
      cur.phase         = lbf_pkg::PH_SCAN;
      cur.col           = '0;
      cur.in_word       = 1'b0;
      cur.last_word_end = '0;
      cur.word_end_seen = 1'b0;
      cur.byte_index    = '0;
    end
  end

  assign is_blank = (char_code == lbf_pkg::CH_SPACE) ||
                    ((char_code >= lbf_pkg::CH_TAB) && (char_code <= lbf_pkg::CH_CR));
  assign is_ctrl_or_high = char_code[7] || (char_code < lbf_pkg::CH_SPACE);
  assign index_inc = (cur.byte_index == lbf_pkg::OFFSET_MAX) ?
                     cur.byte_index : cur.byte_index + 1'b1;
  assign tab_step = (lbf_pkg::TAB_BITS+1)'(lbf_pkg::TAB_WIDTH) -
                    {1'b0, cur.col[lbf_pkg::TAB_BITS-1:0]};

  always_comb begin
    if (char_code == lbf_pkg::CH_TAB) begin
      col_add = lbf_pkg::COL_BITS'(tab_step);
    end else if ((char_code == lbf_pkg::CH_SPACE) || !is_ctrl_or_high) begin
      col_add = lbf_pkg::COL_BITS'(1);
    end else begin
      col_add = lbf_pkg::COL_BITS'(2);
    end
  end

  always_comb begin
    state_next     = cur;
    result.emit    = 1'b0;
    result.offset  = cur.byte_index;
    result.outcome = lbf_pkg::OUT_END_TEXT;
    if (start_of_text && (max_width == '0)) begin
      state_next.phase = lbf_pkg::PH_DONE;
      result.emit      = 1'b1;
      result.offset    = '0;
      result.outcome   = lbf_pkg::OUT_NO_BREAK;
    end else begin
      unique case (cur.phase)
        lbf_pkg::PH_EXTEND: begin
          if ((char_code == lbf_pkg::CH_NUL) || is_blank) begin
            state_next.phase = lbf_pkg::PH_DONE;
            result.emit      = 1'b1;
            result.outcome   = lbf_pkg::OUT_OVF_EXTEND;
          end else begin
            state_next.byte_index = index_inc;
          end
        end
        lbf_pkg::PH_SCAN: begin
          if (char_code == lbf_pkg::CH_NUL) begin
            state_next.phase = lbf_pkg::PH_DONE;
            result.emit      = 1'b1;
          end else if ((char_code == lbf_pkg::CH_LF) || (char_code == lbf_pkg::CH_CR)) begin
            state_next.phase = lbf_pkg::PH_DONE;
            result.emit      = 1'b1;
            result.outcome   = lbf_pkg::OUT_NEWLINE;
            if (!cur.in_word && cur.word_end_seen) begin
              result.offset = cur.last_word_end;
            end
          end else begin
            state_next.col        = cur.col + col_add;
            state_next.byte_index = index_inc;
            if ((char_code == lbf_pkg::CH_TAB) || (char_code == lbf_pkg::CH_SPACE)) begin
              if (cur.in_word) begin
                state_next.last_word_end = cur.byte_index;
                state_next.word_end_seen = 1'b1;
                state_next.in_word       = 1'b0;
              end
            end else begin
              state_next.in_word = 1'b1;
            end
            if (state_next.col >= {1'b0, max_width}) begin
              if (state_next.in_word && !state_next.word_end_seen) begin
                if (overflow_report) begin
                  state_next.phase = lbf_pkg::PH_DONE;
                  result.emit      = 1'b1;
                  result.offset    = index_inc;
                  result.outcome   = lbf_pkg::OUT_OVF_REPORT;
                end else begin
                  state_next.phase = lbf_pkg::PH_EXTEND;
                end
              end else if (state_next.word_end_seen) begin
                state_next.phase = lbf_pkg::PH_DONE;
                result.emit      = 1'b1;
                result.offset    = state_next.last_word_end;
                result.outcome   = lbf_pkg::OUT_WORD_BREAK;
              end else begin
                state_next.phase = lbf_pkg::PH_DONE;
                result.emit      = 1'b1;
                result.offset    = '0;
                result.outcome   = lbf_pkg::OUT_NO_BREAK;
              end
            end
          end
        end
        default: begin
          state_next = cur;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/lbf_out_reg.sv
// Result register on the master side of the line break finder.
// Depends on lbf_pkg.
module lbf_out_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  lbf_pkg::lbf_result_t            result,
  output logic                            free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lbf_pkg::OFFSET_BITS-1:0] m_tdata,   // break_offset
  output logic [lbf_pkg::OUTCOME_BITS-1:0] m_tuser   // outcome
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      m_tdata <= result.offset;
      m_tuser <= result.outcome;
    end
  end

endmodule

// File: hw/rtl/line_break_finder.sv
// Top level of the line break finder: input register, scan state, config registers.
// Depends on lbf_pkg, lbf_step and lbf_out_reg.
//
// The block takes one text byte per cycle and gives at most one break result per
// scan. An accepted byte is held in the input register and is folded into
// the scan state by the step logic. Its result, if any, loads into the result
// register once that register is free, and is then valid on the master side.
// The input register and the result register together sustain one byte per
// cycle while m_tready does not stall them. A stall on m_tready holds the result
// register and, once that is full, the input register.
// Configuration is taken in any cycle and must only be written while idle.
module line_break_finder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lbf_pkg::CHAR_BITS-1:0]     s_tdata,   // char_code
  input  logic                              s_tuser,   // start_of_text
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lbf_pkg::OFFSET_BITS-1:0]   m_tdata,   // break_offset
  output logic [lbf_pkg::OUTCOME_BITS-1:0]  m_tuser,   // outcome
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lbf_pkg::WIDTH_BITS-1:0]    cfg_data
);

  logic                             in_valid;
  logic [lbf_pkg::CHAR_BITS-1:0]    in_char;
  logic                             in_start;
  logic                             out_free;
  logic                             advance;
  logic [lbf_pkg::WIDTH_BITS-1:0]   max_width;
  logic                             overflow_report;
  lbf_pkg::lbf_state_t              state;
  lbf_pkg::lbf_state_t              state_next;
  lbf_pkg::lbf_result_t             result;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width       <= lbf_pkg::MAX_WIDTH_RESET;
      overflow_report <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lbf_pkg::lbf_reg_t'(cfg_index))
        lbf_pkg::REG_MAX_WIDTH:       max_width       <= cfg_data;
        lbf_pkg::REG_OVERFLOW_REPORT: overflow_report <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= lbf_pkg::PH_DONE;
      state.col           <= '0;
      state.in_word       <= 1'b0;
      state.last_word_end <= '0;
      state.word_end_seen <= 1'b0;
      state.byte_index    <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  lbf_step u_step (
    .char_code       (in_char),
    .start_of_text   (in_start),
    .state           (state),
    .max_width       (max_width),
    .overflow_report (overflow_report),
    .state_next      (state_next),
    .result          (result)
  );

  lbf_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && result.emit),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_zero_width_no_break: assert property (@(posedge clk) disable iff (rst)
    (advance && in_start && (max_width == '0)) |=>
      (m_tvalid && (m_tuser == lbf_pkg::OUT_NO_BREAK) && (m_tdata == '0)))
    else $error("zero width start did not give an immediate no-break result");

  a_index_monotonic: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_start) |=> (state.byte_index >= $past(state.byte_index)))
    else $error("byte index went backward within a scan");

  a_extend_only_first_word: assert property (@(posedge clk) disable iff (rst)
    (state.phase == lbf_pkg::PH_EXTEND) |-> (state.in_word && !state.word_end_seen))
    else $error("extend phase entered outside an overlong first word");

  a_outcome_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= lbf_pkg::OUT_OVF_EXTEND))
    else $error("result outcome out of range");

  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    (advance && result.emit) |=> (state.phase == lbf_pkg::PH_DONE))
    else $error("scan kept running after a result");

endmodule

// File: dv/line_break_finder_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for line_break_finder: directed table, an extend run, then random line scans.
// Depends on lbf_pkg and the line_break_finder RTL; a built-in predictor checks breaks.
module line_break_finder_tb;

  localparam int CLK_PERIOD  = 8;
  localparam int RST_CYCLES  = 8;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int EXTEND_RUN  = 100;
  localparam int PHASE_BYTES = 150;

  typedef struct packed {
    logic [lbf_pkg::OFFSET_BITS-1:0] offset;
    lbf_pkg::lbf_outcome_t           outcome;
  } brk_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_TYPED
  } row_chk_t;

  typedef struct packed {
    logic                           is_cfg;
    logic [lbf_pkg::WIDTH_BITS-1:0] w;
    logic                           ovf;
    logic [lbf_pkg::CHAR_BITS-1:0]  ch;
    logic                           sot;
    row_chk_t                       chk;
    brk_t                           want;
  } stim_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [lbf_pkg::CHAR_BITS-1:0]    s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [lbf_pkg::OFFSET_BITS-1:0]  m_tdata;
  logic [lbf_pkg::OUTCOME_BITS-1:0] m_tuser;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [lbf_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [lbf_pkg::WIDTH_BITS-1:0]   cfg_data = '0;

  // predictor state and its copy of the registers
  logic [lbf_pkg::WIDTH_BITS-1:0]  wrap_width = lbf_pkg::MAX_WIDTH_RESET;
  bit                              ovf_now = 1'b0;
  lbf_pkg::lbf_phase_t             scan_ph = lbf_pkg::PH_DONE;
  logic [lbf_pkg::COL_BITS-1:0]    col = '0;
  bit                              in_word = 1'b0;
  logic [lbf_pkg::OFFSET_BITS-1:0] word_end_at = '0;
  bit                              word_end_seen = 1'b0;
  logic [lbf_pkg::OFFSET_BITS-1:0] byte_at = '0;

  brk_t      breaks_due[$];
  stim_row_t script[$];
  brk_t      oldest;
  int        errors = 0;
  int        breaks_seen = 0;
  int        live_bytes = 0;
  int        bytes_sent = 0;
  int        settings_used = 0;
  int        cycles = 0;
  int        ready_hold = 0;
  bit        calm = 1'b0;

  line_break_finder DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  function automatic bit next_break(input logic [lbf_pkg::CHAR_BITS-1:0] ch, input bit sot,
                                    output brk_t res);
    bit hit;
    bit blank;
    hit = 1'b0;
    res = '0;
    blank = (ch == lbf_pkg::CH_SPACE) || (ch >= lbf_pkg::CH_TAB && ch <= lbf_pkg::CH_CR);
    if (sot) begin
      col = '0;
      in_word = 1'b0;
      word_end_at = '0;
      word_end_seen = 1'b0;
      byte_at = '0;
      scan_ph = lbf_pkg::PH_SCAN;
    end
    if (sot && wrap_width == '0) begin
      hit = 1'b1;
      res.outcome = lbf_pkg::OUT_NO_BREAK;
    end else if (scan_ph == lbf_pkg::PH_EXTEND) begin
      if (ch == lbf_pkg::CH_NUL || blank) begin
        hit = 1'b1;
        res.offset = byte_at;
        res.outcome = lbf_pkg::OUT_OVF_EXTEND;
      end else if (byte_at != lbf_pkg::OFFSET_MAX) begin
        byte_at++;
      end
    end else if (scan_ph == lbf_pkg::PH_SCAN) begin
      if (ch == lbf_pkg::CH_NUL) begin
        hit = 1'b1;
        res.offset = byte_at;
        res.outcome = lbf_pkg::OUT_END_TEXT;
      end else if (ch == lbf_pkg::CH_LF || ch == lbf_pkg::CH_CR) begin
        hit = 1'b1;
        res.offset = (in_word || !word_end_seen) ? byte_at : word_end_at;
        res.outcome = lbf_pkg::OUT_NEWLINE;
      end else begin
        if (ch == lbf_pkg::CH_TAB || ch == lbf_pkg::CH_SPACE) begin
          if (ch == lbf_pkg::CH_TAB)
            col = col + lbf_pkg::COL_BITS'(lbf_pkg::TAB_WIDTH - (col % lbf_pkg::TAB_WIDTH));
          else col = col + 1'b1;
          if (in_word) begin
            word_end_at = byte_at;
            word_end_seen = 1'b1;
            in_word = 1'b0;
          end
        end else begin
          col = col + lbf_pkg::COL_BITS'((ch < 8'd32 || ch >= 8'd128) ? 2 : 1);
          in_word = 1'b1;
        end
        if (byte_at != lbf_pkg::OFFSET_MAX) byte_at++;
        if (col >= wrap_width) begin
          if (in_word && !word_end_seen) begin
            if (ovf_now) begin
              hit = 1'b1;
              res.offset = byte_at;
              res.outcome = lbf_pkg::OUT_OVF_REPORT;
            end else begin
              scan_ph = lbf_pkg::PH_EXTEND;
            end
          end else begin
            hit = 1'b1;
            res.offset = word_end_seen ? word_end_at : '0;
            res.outcome = word_end_seen ? lbf_pkg::OUT_WORD_BREAK : lbf_pkg::OUT_NO_BREAK;
          end
        end
      end
    end
    if (hit) scan_ph = lbf_pkg::PH_DONE;
    return hit;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [lbf_pkg::CHAR_BITS-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(97, 122));
    if (r < 68) return lbf_pkg::CH_SPACE;
    if (r < 74) return lbf_pkg::CH_TAB;
    if (r < 77) return lbf_pkg::CH_LF;
    if (r < 79) return lbf_pkg::CH_CR;
    if (r < 81) return lbf_pkg::CH_NUL;
    if (r < 85) return 8'($urandom_range(1, 31));
    if (r < 91) return 8'($urandom_range(128, 255));
    if (r < 94) return 8'($urandom_range(11, 12));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [lbf_pkg::CHAR_BITS-1:0] ch, input bit sot,
                           input row_chk_t chk, input brk_t want);
    int   gap;
    bit   hit;
    brk_t res;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tuser <= sot;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (sot || scan_ph != lbf_pkg::PH_DONE) live_bytes++;
    hit = next_break(ch, sot, res);
    unique case (chk)
      ROW_SILENT: begin
        if (hit) report($sformatf("table row 0x%02h expects no break, predictor has one", ch));
      end
      ROW_TYPED: begin
        if (!hit || res !== want)
          report($sformatf("table row 0x%02h disagrees with predictor", ch));
        breaks_due.push_back(want);
      end
      default: begin
        if (hit) breaks_due.push_back(res);
      end
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (breaks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_wrap(input logic [lbf_pkg::WIDTH_BITS-1:0] w, input bit ovf);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= lbf_pkg::REG_MAX_WIDTH;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= lbf_pkg::REG_OVERFLOW_REPORT;
    cfg_data <= lbf_pkg::WIDTH_BITS'(ovf);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wrap_width = w;
    ovf_now = ovf;
    settings_used++;
  endtask

  task automatic run_scans(input int budget);
    int stop_at;
    int len;
    int r;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, ROW_PREDICT, '0);
      end else begin
        len = $urandom_range(1, 40);
        send_byte(pick_char(), 1'b1, ROW_PREDICT, '0);
        repeat (len) send_byte(pick_char(), $urandom_range(0, 49) == 0, ROW_PREDICT, '0);
        r = $urandom_range(0, 5);
        if (r < 3)
          send_byte(r == 0 ? lbf_pkg::CH_NUL : (r == 1 ? lbf_pkg::CH_LF : lbf_pkg::CH_CR),
                    1'b0, ROW_PREDICT, '0);
      end
    end
  endtask

  function automatic void put_byte(input logic [lbf_pkg::CHAR_BITS-1:0] ch, input bit sot,
                                   input row_chk_t chk,
                                   input logic [lbf_pkg::OFFSET_BITS-1:0] off,
                                   input lbf_pkg::lbf_outcome_t oc);
    stim_row_t r;
    r = '0;
    r.ch = ch;
    r.sot = sot;
    r.chk = chk;
    r.want.offset = off;
    r.want.outcome = oc;
    script.push_back(r);
  endfunction

  function automatic void put_cfg(input logic [lbf_pkg::WIDTH_BITS-1:0] w, input bit ovf);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.w = w;
    r.ovf = ovf;
    script.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      breaks_seen++;
      if (breaks_due.size() == 0) begin
        report($sformatf("unexpected break offset %0d outcome %0d", m_tdata, m_tuser));
      end else begin
        oldest = breaks_due.pop_front();
        if (m_tdata !== oldest.offset)
          report($sformatf("offset %0d, want %0d", m_tdata, oldest.offset));
        if (m_tuser !== oldest.outcome)
          report($sformatf("outcome %0d, want %0d", m_tuser, oldest.outcome));
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (calm || $urandom_range(0, 3) != 0) begin
      m_tready <= 1'b1;
      ready_hold = $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b0;
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // reset defaults: width 80, extend on overflow
    put_byte("a",               1'b0, ROW_SILENT,  '0,    lbf_pkg::OUT_END_TEXT);
    put_byte(lbf_pkg::CH_NUL,   1'b1, ROW_TYPED,   16'd0, lbf_pkg::OUT_END_TEXT);
    put_byte("x",               1'b0, ROW_SILENT,  '0,    lbf_pkg::OUT_END_TEXT);
    put_byte(lbf_pkg::CH_LF,    1'b1, ROW_TYPED,   16'd0, lbf_pkg::OUT_NEWLINE);
    put_byte("a",               1'b1, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_byte(lbf_pkg::CH_SPACE, 1'b0, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_byte(lbf_pkg::CH_CR,    1'b0, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_cfg(12'd1, 1'b0);
    put_byte(lbf_pkg::CH_SPACE, 1'b1, ROW_TYPED,   16'd0, lbf_pkg::OUT_NO_BREAK);
    put_byte(8'd255,            1'b1, ROW_SILENT,  '0,    lbf_pkg::OUT_END_TEXT);
    put_byte("q",               1'b0, ROW_SILENT,  '0,    lbf_pkg::OUT_END_TEXT);
    put_byte(8'd11,             1'b0, ROW_TYPED,   16'd2, lbf_pkg::OUT_OVF_EXTEND);
    put_cfg(12'd1, 1'b1);
    put_byte(8'd128,            1'b1, ROW_TYPED,   16'd1, lbf_pkg::OUT_OVF_REPORT);
    put_cfg(12'd0, 1'b1);
    put_byte("z",               1'b1, ROW_TYPED,   16'd0, lbf_pkg::OUT_NO_BREAK);
    put_byte("y",               1'b0, ROW_SILENT,  '0,    lbf_pkg::OUT_END_TEXT);
    put_cfg(12'd4095, 1'b1);
    put_byte(lbf_pkg::CH_TAB,   1'b1, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_byte("a",               1'b0, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_byte("b",               1'b0, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_byte(lbf_pkg::CH_NUL,   1'b0, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_cfg(12'd9, 1'b0);
    put_byte("a",               1'b1, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_byte(lbf_pkg::CH_SPACE, 1'b0, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_byte(lbf_pkg::CH_TAB,   1'b0, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_byte("x",               1'b0, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);
    put_cfg(12'd1, 1'b0);
    put_byte("a",               1'b1, ROW_SILENT,  '0,    lbf_pkg::OUT_END_TEXT);
    put_byte("b",               1'b1, ROW_SILENT,  '0,    lbf_pkg::OUT_END_TEXT);
    put_byte(lbf_pkg::CH_SPACE, 1'b0, ROW_PREDICT, '0,    lbf_pkg::OUT_END_TEXT);

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) set_wrap(script[i].w, script[i].ovf);
      else send_byte(script[i].ch, script[i].sot, script[i].chk, script[i].want);
    end

    // overlong first word held in extend over a long run of letters
    set_wrap(12'd1, 1'b0);
    calm = 1'b1;
    send_byte("a", 1'b1, ROW_PREDICT, '0);
    repeat (EXTEND_RUN) send_byte("x", 1'b0, ROW_PREDICT, '0);
    send_byte(lbf_pkg::CH_SPACE, 1'b0, ROW_PREDICT, '0);
    calm = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      unique case (ph)
        0: set_wrap(12'd1, 1'b1);
        1: set_wrap(12'd1, 1'b0);
        2: set_wrap(12'($urandom_range(2, 12)), 1'b1);
        3: set_wrap(12'($urandom_range(2, 12)), 1'b0);
        4: set_wrap(12'($urandom_range(13, 40)), 1'b0);
        5: set_wrap(12'($urandom_range(13, 40)), 1'b1);
        6: set_wrap(12'd4095, 1'b0);
        default: set_wrap(12'($urandom_range(41, 200)), 1'b1);
      endcase
      calm = (ph == 2 || ph == 5);
      run_scans(PHASE_BYTES);
    end
    calm = 1'b0;
    drain();

    $display("Sent %0d bytes (%0d inside scans) over %0d width/overflow settings.",
             bytes_sent, live_bytes, settings_used);
    $display("Checked %0d breaks against the predictor.", breaks_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
